/* rtl/sem_pkg.sv */
// Shared types, constants and a helper function of the Sobel edge magnitude block.
package sem_pkg;

    // Configuration register indexes and widths
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RESET = 11'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET = 11'd480;

    // Pixel and arithmetic widths
    localparam int CH_W = 8;
    localparam int NUM_CH = 3;
    localparam int PIX_W = CH_W * NUM_CH;
    localparam int GRAD_W = 11;
    localparam int SUM_W = 21;
    localparam int ROOT_W = 8;
    localparam int VAL_W = 16;
    localparam logic [SUM_W-1:0] SAT_LIMIT = 21'd65280;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic {
        F_IDLE,
        F_LOAD
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SQUARE,
        B_ROOT,
        B_FINAL
    } back_state_t;

    typedef struct packed {
        logic [GRAD_W-1:0] gx;
        logic [GRAD_W-1:0] gy;
    } grad_t;

    // One queued job: gradients of the three channels and the frame end flag
    typedef struct packed {
        grad_t [NUM_CH-1:0] grad;
        logic               last;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Gradients of a 3x3 neighbourhood, a[0] top left in raster order.
    function automatic grad_t sobel_grad(input logic [8:0][CH_W-1:0] a);
        logic signed [GRAD_W-1:0] e [9];
        grad_t g;
        for (int i = 0; i < 9; i++)
        begin
            e[i] = $signed({{(GRAD_W-CH_W){1'b0}}, a[i]});
        end
        g.gx = (e[2] - e[0]) + ((e[5] - e[3]) <<< 1) + (e[8] - e[6]);
        g.gy = (e[6] - e[0]) + ((e[7] - e[1]) <<< 1) + (e[8] - e[2]);
        return g;
    endfunction

endpackage

/* rtl/sem_ifs.sv */
// Handshake interfaces for pixel input, edge output and configuration writes.
interface sem_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    modport source (output valid, op, red_in, green_in, blue_in, input ready);
    modport sink (input valid, op, red_in, green_in, blue_in, output ready);
endinterface

interface sem_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_edge;
    logic [7:0] green_edge;
    logic [7:0] blue_edge;
    logic       frame_last;
    modport source (output valid, red_edge, green_edge, blue_edge, frame_last, input ready);
    modport sink (input valid, red_edge, green_edge, blue_edge, frame_last, output ready);
endinterface

interface sem_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [10:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/sem_ram.sv */
// Generic single write port RAM with a registered read port.
module sem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

/* rtl/sem_queue.sv */
// Two-entry queue of gradient jobs between the front and the back.
module sem_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sem_pkg::q_entry_t push_data,
    input  logic              pop,
    output sem_pkg::q_entry_t pop_data,
    output sem_pkg::q_status_t stat
);
    import sem_pkg::*;

    q_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign stat.full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty) else $error("queue popped while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on a lone push");
`endif
endmodule

/* rtl/sem_front.sv */
// Front end: takes pixels, tracks frame position, runs line stores and window, forms gradients.
module sem_front #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    sem_in_if.sink             pix_in,
    sem_cfg_if.sink            cfg,
    output logic               q_push,
    output sem_pkg::q_entry_t  q_data,
    input  sem_pkg::q_status_t q_stat
);
    import sem_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    front_state_t            state_reg, state_next;
    logic [CFG_DATA_W-1:0]   width_reg;
    logic [CFG_DATA_W-1:0]   height_reg;
    logic [CW-1:0]           in_col_reg, in_col_next;
    logic [RW-1:0]           in_row_reg, in_row_next;
    logic [CW-1:0]           out_col_reg, out_col_next;
    logic [RW-1:0]           out_row_reg, out_row_next;
    logic [PIX_W-1:0]        win_reg [9];
    logic [PIX_W-1:0]        win_next [9];
    logic [PIX_W-1:0]        bot_reg;
    logic [PIX_W-1:0]        upper_rdata;
    logic [PIX_W-1:0]        lower_rdata;
    logic [WW-1:0]           w_eff;
    logic [HW-1:0]           h_eff;
    logic                    accept;
    logic                    load;
    logic                    produce;
    logic [PIX_W-1:0]        sel [9];
    logic [8:0][CH_W-1:0]    chan [NUM_CH];

    // Effective frame size: zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
        if (height_reg == '0)
            h_eff = HW'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(height_reg);
    end

    assign pix_in.ready = (state_reg == F_IDLE) && !q_stat.full;
    assign cfg.ready = 1'b1;
    assign accept = pix_in.valid && pix_in.ready;
    assign load = (state_reg == F_LOAD);

    // Line stores: rows two back and one back, read at the current column
    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (load),
        .waddr (in_col_reg),
        .wdata (lower_rdata),
        .raddr (in_col_reg),
        .rdata (upper_rdata)
    );

    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
        .clk   (clk),
        .we    (load),
        .waddr (in_col_reg),
        .wdata (bot_reg),
        .raddr (in_col_reg),
        .rdata (lower_rdata)
    );

    // State sequencing and position counters
    always_comb
    begin
        state_next = state_reg;
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        produce = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                    state_next = F_LOAD;
            end
            F_LOAD:
            begin
                state_next = F_IDLE;
                produce = (32'(in_row_reg) >= 32'd2) ||
                          ((in_row_reg == RW'(1)) && (in_col_reg != '0));
                if (produce)
                begin
                    if (32'(out_col_reg) + 32'd1 >= 32'(w_eff))
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                end
                if (32'(in_row_reg) >= 32'(h_eff) + 32'd1)
                begin
                    in_col_next = '0;
                    in_row_next = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (32'(in_col_reg) + 32'd1 >= 32'(w_eff))
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + 1'b1;
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Window shift and border masking
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3+0] = win_reg[r*3+1];
            win_next[r*3+1] = win_reg[r*3+2];
        end
        win_next[2] = upper_rdata;
        win_next[5] = lower_rdata;
        win_next[8] = bot_reg;
        for (int i = 0; i < 9; i++)
        begin
            sel[i] = win_next[i];
        end
        for (int r = 0; r < 3; r++)
        begin
            if (out_row_reg == '0)
                sel[r] = '0;
            if (32'(out_row_reg) == 32'(h_eff) - 32'd1)
                sel[6+r] = '0;
            if (out_col_reg == '0)
                sel[r*3] = '0;
            if (32'(out_col_reg) == 32'(w_eff) - 32'd1)
                sel[r*3+2] = '0;
        end
        for (int c = 0; c < NUM_CH; c++)
        begin
            for (int i = 0; i < 9; i++)
            begin
                chan[c][i] = sel[i][(NUM_CH-1-c)*CH_W +: CH_W];
            end
        end
    end

    // Gradient job for the queue; channel 0 is red
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            q_data.grad[c] = sobel_grad(chan[c]);
        end
        q_data.last = (32'(out_row_reg) == 32'(h_eff) - 32'd1) &&
                      (32'(out_col_reg) == 32'(w_eff) - 32'd1);
    end
    assign q_push = load && produce;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            width_reg <= FRAME_WIDTH_RESET;
            height_reg <= FRAME_HEIGHT_RESET;
            in_col_reg <= '0;
            in_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    win_reg[i] <= win_next[i];
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_FRAME_WIDTH)
                    width_reg <= cfg.data;
                else
                    height_reg <= cfg.data;
                in_col_reg <= '0;
                in_row_reg <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else
            begin
                in_col_reg <= in_col_next;
                in_row_reg <= in_row_next;
                out_col_reg <= out_col_next;
                out_row_reg <= out_row_next;
            end
        end
    end

    // Bottom row pixel of the accepted item; flushes and drain rows are black
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if ((32'(in_row_reg) < 32'(h_eff)) && !pix_in.op)
                bot_reg <= {pix_in.red_in, pix_in.green_in, pix_in.blue_in};
            else
                bot_reg <= '0;
        end
    end

`ifndef ASSERT_OFF
    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == F_LOAD |=> state_reg == F_IDLE) else $error("load phase stuck");
    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        32'(in_col_reg) < 32'(w_eff)) else $error("input column beyond frame width");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full) else $error("push into a full queue");
`endif
endmodule

/* rtl/sem_back.sv */
// Back end: squares the gradients, takes a rounded square root per channel, holds the result.
module sem_back (
    input  logic               clk,
    input  logic               rst_n,
    output logic               q_pop,
    input  sem_pkg::q_entry_t  q_data,
    input  sem_pkg::q_status_t q_stat,
    sem_out_if.source          edge_out
);
    import sem_pkg::*;

    back_state_t        state_reg, state_next;
    q_entry_t           job_reg;
    logic [VAL_W-1:0]   val_reg [NUM_CH];
    logic [NUM_CH-1:0]  sat_reg;
    logic [ROOT_W-1:0]  root_reg [NUM_CH];
    logic [ROOT_W-1:0]  root_next [NUM_CH];
    logic [2:0]         bit_reg;
    logic               out_valid_reg;
    logic [CH_W-1:0]    res_reg [NUM_CH];
    logic [CH_W-1:0]    res_next [NUM_CH];
    logic               last_reg;
    logic               out_free;
    logic [SUM_W-1:0]   sum [NUM_CH];

    assign out_free = !out_valid_reg || edge_out.ready;
    assign edge_out.valid = out_valid_reg;
    assign edge_out.red_edge = res_reg[0];
    assign edge_out.green_edge = res_reg[1];
    assign edge_out.blue_edge = res_reg[2];
    assign edge_out.frame_last = last_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        q_pop = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop = 1'b1;
                    state_next = B_SQUARE;
                end
            end
            B_SQUARE:
            begin
                state_next = B_ROOT;
            end
            B_ROOT:
            begin
                if (bit_reg == '0)
                    state_next = B_FINAL;
            end
            B_FINAL:
            begin
                if (out_free)
                    state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Sum of squares, one root bit per cycle, and the rounding step
    always_comb
    begin
        logic signed [2*GRAD_W-1:0] sqx;
        logic signed [2*GRAD_W-1:0] sqy;
        logic [ROOT_W-1:0]          trial;
        logic [VAL_W-1:0]           fsq;
        logic [VAL_W-1:0]           diff;
        for (int c = 0; c < NUM_CH; c++)
        begin
            sqx = $signed(job_reg.grad[c].gx) * $signed(job_reg.grad[c].gx);
            sqy = $signed(job_reg.grad[c].gy) * $signed(job_reg.grad[c].gy);
            sum[c] = SUM_W'($unsigned(sqx)) + SUM_W'($unsigned(sqy));
            trial = root_reg[c] | (ROOT_W'(1) << bit_reg);
            if (VAL_W'(trial) * VAL_W'(trial) <= val_reg[c])
                root_next[c] = trial;
            else
                root_next[c] = root_reg[c];
            fsq = VAL_W'(root_reg[c]) * VAL_W'(root_reg[c]);
            diff = val_reg[c] - fsq;
            if (sat_reg[c])
                res_next[c] = '1;
            else if (diff <= VAL_W'(root_reg[c]))
                res_next[c] = root_reg[c];
            else
                res_next[c] = root_reg[c] + 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_FINAL && out_free)
                out_valid_reg <= 1'b1;
            else if (edge_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_data;
        end
        case (state_reg)
            B_SQUARE:
            begin
                bit_reg <= 3'd7;
                for (int c = 0; c < NUM_CH; c++)
                begin
                    sat_reg[c] <= sum[c] > SAT_LIMIT;
                    val_reg[c] <= sum[c][VAL_W-1:0];
                    root_reg[c] <= '0;
                end
            end
            B_ROOT:
            begin
                bit_reg <= bit_reg - 1'b1;
                for (int c = 0; c < NUM_CH; c++)
                begin
                    root_reg[c] <= root_next[c];
                end
            end
            B_FINAL:
            begin
                if (out_free)
                begin
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        res_reg[c] <= res_next[c];
                    end
                    last_reg <= job_reg.last;
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == B_IDLE) else $error("pop outside idle");
    a_square_to_root: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_SQUARE |=> state_reg == B_ROOT && bit_reg == 3'd7)
        else $error("root iteration did not start at the top bit");
    a_root_holds_sat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_ROOT |=> $stable(sat_reg)) else $error("saturation flag changed");
`endif
endmodule

/* rtl/sobel_edge_magnitude_rgb.sv */
// Top level of the streaming 3x3 Sobel edge magnitude block for RGB pixels.
//
//   Channel   Role    Payload
//   pix_in    sink    op, red_in, green_in, blue_in
//   edge_out  source  red_edge, green_edge, blue_edge, frame_last
//   cfg       sink    index (0 frame_width, 1 frame_height), data
//
// The front handles an item as a line store read, then a window update, and takes
// no new item until the update is done. The back handles a result as a queue pop,
// a squaring step, a bit-per-cycle square root and a rounding step; it sets the rate.
// A two-entry queue lets the front run ahead while the back or the output stalls.
// Reset clears the counters, window and queue; the line stores are not cleared.
module sobel_edge_magnitude_rgb #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    sem_in_if.sink     pix_in,
    sem_out_if.source  edge_out,
    sem_cfg_if.sink    cfg
);
    import sem_pkg::*;

    logic      q_push;
    logic      q_pop;
    q_entry_t  q_wdata;
    q_entry_t  q_rdata;
    q_status_t q_stat;

    sem_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pix_in (pix_in),
        .cfg    (cfg),
        .q_push (q_push),
        .q_data (q_wdata),
        .q_stat (q_stat)
    );

    sem_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .stat      (q_stat)
    );

    sem_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_pop    (q_pop),
        .q_data   (q_rdata),
        .q_stat   (q_stat),
        .edge_out (edge_out)
    );
endmodule

/* tb/tb_sobel_edge_magnitude_rgb.sv */
// Self-checking testbench of the streaming Sobel edge magnitude block.
module tb_sobel_edge_magnitude_rgb;
    timeunit 1ns;
    timeprecision 1ps;
    import sem_pkg::*;

    localparam int LINE_MAX = 1024;
    localparam int CYCLE_LIMIT = 1500000;
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } edge_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sem_in_if pix_in();
    sem_out_if edge_out();
    sem_cfg_if cfg();

    sobel_edge_magnitude_rgb dut (
        .clk(clk),
        .rst_n(rst_n),
        .pix_in(pix_in.sink),
        .edge_out(edge_out.source),
        .cfg(cfg.sink)
    );

    always #5 clk = ~clk;

    // Predictor state: line stores, window, stream position and frame size
    logic [23:0] upper_row [LINE_MAX];
    logic [23:0] lower_row [LINE_MAX];
    logic [23:0] win [9];
    int unsigned in_col, in_row, out_col, out_row;
    logic [10:0] width_reg, height_reg;

    edge_t expected_edges[$];
    int errors = 0;
    int results_seen = 0;
    int items_sent = 0;
    int frames_done = 0;
    longint cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;

    // Report one mismatch and count it
    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    function automatic int unsigned clamped(input logic [10:0] v);
        if (v == 0)
            return 1;
        if (v > LINE_MAX)
            return LINE_MAX;
        return 32'(v);
    endfunction

    function automatic logic [7:0] channel_magnitude(input logic [23:0] w [9], input int sh);
        int a [9];
        int gx, gy, s, n;
        for (int i = 0; i < 9; i++)
        begin
            a[i] = int'((w[i] >> sh) & 24'hFF);
        end
        gx = (a[2] - a[0]) + 2 * (a[5] - a[3]) + (a[8] - a[6]);
        gy = (a[6] - a[0]) + 2 * (a[7] - a[1]) + (a[8] - a[2]);
        s = gx * gx + gy * gy;
        if (s > 65280)
            return 8'd255;
        n = 0;
        while (n < 255 && n * (n + 1) < s)
            n++;
        return n[7:0];
    endfunction

    function automatic void restart_position();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    // Advance the predictor by one accepted item
    function automatic void predict_edge(input logic op, input logic [23:0] pix);
        int unsigned w, h, ic;
        logic [23:0] bot;
        logic [23:0] old [9];
        logic [23:0] sel [9];
        logic [23:0] col [3];
        edge_t e;
        w = clamped(width_reg);
        h = clamped(height_reg);
        if (in_col >= w || in_row > h + 1)
            restart_position();
        ic = in_col;
        bot = (in_row < h && op == OP_PIXEL) ? pix : 24'd0;
        col[0] = upper_row[ic];
        col[1] = lower_row[ic];
        col[2] = bot;
        upper_row[ic] = col[1];
        lower_row[ic] = bot;
        old = win;
        for (int r = 0; r < 3; r++)
        begin
            win[r*3] = win[r*3+1];
            win[r*3+1] = win[r*3+2];
            win[r*3+2] = col[r];
        end
        if (in_row >= 2 || (in_row == 1 && ic >= 1))
        begin
            if (ic == 0)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    sel[r*3] = old[r*3+1];
                    sel[r*3+1] = old[r*3+2];
                    sel[r*3+2] = 24'd0;
                end
            end
            else
                sel = win;
            for (int r = 0; r < 3; r++)
            begin
                if (out_row == 0) sel[r] = 0;
                if (out_row == h - 1) sel[6+r] = 0;
                if (out_col == 0) sel[r*3] = 0;
                if (out_col == w - 1) sel[r*3+2] = 0;
            end
            e.red = channel_magnitude(sel, 16);
            e.green = channel_magnitude(sel, 8);
            e.blue = channel_magnitude(sel, 0);
            e.last = (out_row == h - 1 && out_col == w - 1);
            expected_edges.push_back(e);
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
        if (in_row >= h + 1)
            restart_position();
        else
        begin
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
        end
    endfunction

    // Cycle counter and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver readiness
    always @(posedge clk)
    begin
        if (hold_off)
            edge_out.ready <= 1'b0;
        else
            edge_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && edge_out.valid && edge_out.ready)
        begin
            edge_t e;
            results_seen++;
            if (expected_edges.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                e = expected_edges.pop_front();
                if (edge_out.red_edge !== e.red)
                    report_mismatch($sformatf("red %0d, expected %0d", edge_out.red_edge, e.red));
                if (edge_out.green_edge !== e.green)
                    report_mismatch($sformatf("green %0d, expected %0d",
                                              edge_out.green_edge, e.green));
                if (edge_out.blue_edge !== e.blue)
                    report_mismatch($sformatf("blue %0d, expected %0d",
                                              edge_out.blue_edge, e.blue));
                if (edge_out.frame_last !== e.last)
                    report_mismatch($sformatf("frame_last %0b, expected %0b",
                                              edge_out.frame_last, e.last));
                if (e.last)
                    frames_done++;
            end
        end
    end

    // Send one item, with optional random idle cycles before it
    task automatic send_item(input logic op, input logic [23:0] pix);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_in.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.op <= op;
        {pix_in.red_in, pix_in.green_in, pix_in.blue_in} <= pix;
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
        predict_edge(op, pix);
        items_sent++;
    endtask

    task automatic wait_drained();
        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (expected_edges.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [10:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        restart_position();
    endtask

    function automatic logic [23:0] random_pixel();
        case ($urandom_range(3))
            0: return {3{8'hFF}} & {$urandom_range(1) ? 8'hFF : 8'h00,
                                    $urandom_range(1) ? 8'hFF : 8'h00,
                                    $urandom_range(1) ? 8'hFF : 8'h00};
            default: return 24'($urandom());
        endcase
    endfunction

    // One whole frame plus its drain; flush or pixels mixed in as asked
    task automatic send_frame(input logic [10:0] w, input logic [10:0] h, input int noise_pct);
        int unsigned cw, ch;
        cw = clamped(w);
        ch = clamped(h);
        for (int i = 0; i < cw * ch; i++)
            send_item(($urandom_range(99) < noise_pct) ? OP_FLUSH : OP_PIXEL, random_pixel());
        for (int i = 0; i <= cw; i++)
            send_item(($urandom_range(99) < noise_pct) ? OP_PIXEL : OP_FLUSH, random_pixel());
    endtask

    task automatic set_frame(input logic [10:0] w, input logic [10:0] h);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // Directed: extremes of pixel values, flush inside a frame, tiny frames
    task automatic test_directed();
        set_frame(11'd3, 11'd3);
        send_item(OP_PIXEL, 24'hFFFFFF);
        send_item(OP_PIXEL, 24'h000000);
        send_item(OP_PIXEL, 24'hFF00FF);
        send_item(OP_FLUSH, 24'hFFFFFF);
        send_item(OP_PIXEL, 24'h00FF00);
        send_item(OP_PIXEL, 24'hFFFFFF);
        send_item(OP_PIXEL, 24'h000000);
        send_item(OP_PIXEL, 24'hAA55AA);
        send_item(OP_PIXEL, 24'hFFFFFF);
        send_item(OP_PIXEL, 24'h123456);
        for (int i = 0; i < 3; i++)
            send_item(OP_FLUSH, 24'h0);
        // Width and height of zero act as one
        set_frame(11'd0, 11'd0);
        send_item(OP_PIXEL, 24'hFFFFFF);
        send_item(OP_FLUSH, 24'h0);
        send_item(OP_PIXEL, 24'h808080);
        // Single row and single column
        set_frame(11'd4, 11'd1);
        send_frame(11'd4, 11'd1, 0);
        set_frame(11'd1, 11'd4);
        send_frame(11'd1, 11'd4, 0);
    endtask

    // Random frames of small sizes under the given idle and stall percentages
    task automatic test_random_frames(input int idle_pct, input int stall_pct, input int n);
        logic [10:0] w, h;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n; k++)
        begin
            w = 11'($urandom_range(1, 8));
            h = 11'($urandom_range(1, 6));
            set_frame(w, h);
            send_frame(w, h, 8);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        set_frame(11'd5, 11'd5);
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            send_frame(11'd5, 11'd5, 0);
        join
        // Sender pauses mid-frame until every result is in
        send_frame(11'd5, 11'd2, 0);
        set_frame(11'd4, 11'd4);
        for (int i = 0; i < 10; i++)
            send_item(OP_PIXEL, random_pixel());
        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (expected_edges.size() != 0)
            @(posedge clk);
        for (int i = 0; i < 11; i++)
            send_item(OP_PIXEL, random_pixel());
    endtask

    // Largest width, and out-of-range size values that clamp, on partial frames
    task automatic test_extreme_sizes();
        set_frame(11'd1024, 11'd2);
        for (int i = 0; i < 100; i++)
            send_item(OP_PIXEL, random_pixel());
        set_frame(11'd2047, 11'd1);
        for (int i = 0; i < 100; i++)
            send_item(OP_PIXEL, random_pixel());
        set_frame(11'd3, 11'd1024);
        for (int i = 0; i < 40; i++)
            send_item(OP_PIXEL, random_pixel());
        set_frame(11'd2, 11'd2047);
        for (int i = 0; i < 20; i++)
            send_item(OP_PIXEL, random_pixel());
    endtask

    initial
    begin
        for (int i = 0; i < LINE_MAX; i++)
        begin
            upper_row[i] = 0;
            lower_row[i] = 0;
        end
        for (int i = 0; i < 9; i++)
            win[i] = 0;
        restart_position();
        width_reg = FRAME_WIDTH_RESET;
        height_reg = FRAME_HEIGHT_RESET;
        pix_in.valid = 1'b0;
        pix_in.op = OP_PIXEL;
        pix_in.red_in = 0;
        pix_in.green_in = 0;
        pix_in.blue_in = 0;
        edge_out.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_FRAME_WIDTH;
        cfg.data = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_frames(0, 0, 6);
        test_random_frames(58, 0, 6);
        test_random_frames(0, 58, 6);
        test_random_frames(18, 18, 6);
        test_backpressure();
        test_extreme_sizes();
        wait_drained();

        $display("Sent %0d items, checked %0d results over %0d frames.",
                 items_sent, results_seen, frames_done);
        $display("Covered tiny frames, flush inside and after frames, clamped sizes and backpressure.");
        if (errors == 0 && expected_edges.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
